FILE: rtl/xmt_pkg.sv
// Types and codes shared by the markup tokenizer and its checker.
package xmt_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned RoleW  = 4;
	localparam int unsigned KindW  = 3;
	localparam int unsigned ErrorW = 3;

	localparam logic [RoleW-1:0] ROLE_SPACE   = 4'd0;
	localparam logic [RoleW-1:0] ROLE_LT      = 4'd1;
	localparam logic [RoleW-1:0] ROLE_SLASH   = 4'd2;
	localparam logic [RoleW-1:0] ROLE_NAME    = 4'd3;
	localparam logic [RoleW-1:0] ROLE_KEY     = 4'd4;
	localparam logic [RoleW-1:0] ROLE_EQ      = 4'd5;
	localparam logic [RoleW-1:0] ROLE_OPENQ   = 4'd6;
	localparam logic [RoleW-1:0] ROLE_VALUE   = 4'd7;
	localparam logic [RoleW-1:0] ROLE_CLOSEQ  = 4'd8;
	localparam logic [RoleW-1:0] ROLE_GT      = 4'd9;
	localparam logic [RoleW-1:0] ROLE_CONTENT = 4'd10;
	localparam logic [RoleW-1:0] ROLE_IGNORED = 4'd11;
	localparam logic [RoleW-1:0] ROLE_END     = 4'd12;

	localparam logic [KindW-1:0] KIND_NONE    = 3'd0;
	localparam logic [KindW-1:0] KIND_START   = 3'd1;
	localparam logic [KindW-1:0] KIND_ENDTAG  = 3'd2;
	localparam logic [KindW-1:0] KIND_CONTENT = 3'd3;
	localparam logic [KindW-1:0] KIND_EOI     = 3'd4;

	localparam logic [ErrorW-1:0] ERR_NONE       = 3'd0;
	localparam logic [ErrorW-1:0] ERR_NAME_START = 3'd1;
	localparam logic [ErrorW-1:0] ERR_ATTR_START = 3'd2;
	localparam logic [ErrorW-1:0] ERR_NO_EQ      = 3'd3;
	localparam logic [ErrorW-1:0] ERR_NO_QUOTE   = 3'd4;
	localparam logic [ErrorW-1:0] ERR_IN_VALUE   = 3'd5;

	localparam logic [CharW-1:0] CH_NUL   = 8'h00;
	localparam logic [CharW-1:0] CH_TAB   = 8'h09;
	localparam logic [CharW-1:0] CH_LF    = 8'h0A;
	localparam logic [CharW-1:0] CH_SP    = 8'h20;
	localparam logic [CharW-1:0] CH_DQ    = 8'h22;
	localparam logic [CharW-1:0] CH_SQ    = 8'h27;
	localparam logic [CharW-1:0] CH_DASH  = 8'h2D;
	localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
	localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
	localparam logic [CharW-1:0] CH_LT    = 8'h3C;
	localparam logic [CharW-1:0] CH_EQ    = 8'h3D;
	localparam logic [CharW-1:0] CH_GT    = 8'h3E;
	localparam logic [CharW-1:0] CH_USCORE = 8'h5F;

	typedef struct packed {
		logic [CharW-1:0] char_in;
		logic             end_of_input;
	} xmt_item_t;

	typedef struct packed {
		logic [CharW-1:0]  char_out;
		logic [RoleW-1:0]  role;
		logic [KindW-1:0]  token_kind;
		logic              token_begins;
		logic              content_closed;
		logic              tag_closed;
		logic              attr_begins;
		logic              attr_closed;
		logic [ErrorW-1:0] error_code;
	} xmt_result_t;

endpackage

FILE: rtl/xml_markup_tokenizer_unit.sv
// Byte-serial tokenizer for a simple XML-like markup, one result per byte.
// Each accepted byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle while results are taken; the input register and
// the result register together let one more byte enter while a result waits to be taken.
// The rate is set by the single phase register, updated once per byte.
// Reset: arst_n clears the valid flags and returns the scanner between tokens.
module xml_markup_tokenizer_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  xmt_pkg::xmt_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output xmt_pkg::xmt_result_t result
);
	import xmt_pkg::*;

	typedef enum logic [3:0] {
		PH_BETWEEN,
		PH_AFTER_LT,
		PH_AFTER_SLASH,
		PH_NAME,
		PH_BODY,
		PH_KEY,
		PH_AFTER_KEY,
		PH_AFTER_EQ,
		PH_VALUE,
		PH_CONTENT,
		PH_ERROR
	} phase_t;

	function automatic logic is_blank(input logic [CharW-1:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF;
	endfunction

	function automatic logic is_name_start(input logic [CharW-1:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
	endfunction

	function automatic logic is_name_char(input logic [CharW-1:0] c);
		return is_name_start(c) || c == CH_DASH || c == CH_DOT || (c >= 8'h30 && c <= 8'h39);
	endfunction

	phase_t      phase_q, phase_d;
	logic        quote_single_q, quote_single_d;
	logic        tag_end_q, tag_end_d;
	logic        valid_s1;
	xmt_item_t   item_s1;
	logic        out_valid_q;
	xmt_result_t out_q;
	xmt_result_t res_d;
	logic        advance;
	logic        move;
	logic [CharW-1:0] c;
	logic        eoi;
	logic [KindW-1:0] tag_kind;
	logic [CharW-1:0] close_quote;

	assign advance    = !out_valid_q || result_ready;
	assign move       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign c           = item_s1.char_in;
	assign eoi         = item_s1.end_of_input || c == CH_NUL;
	assign tag_kind    = tag_end_q ? KIND_ENDTAG : KIND_START;
	assign close_quote = quote_single_q ? CH_SQ : CH_DQ;

	always_comb begin
		res_d          = '0;
		res_d.char_out = c;
		phase_d        = phase_q;
		quote_single_d = quote_single_q;
		tag_end_d      = tag_end_q;
		if (eoi) begin
			res_d.role         = ROLE_END;
			res_d.token_kind   = KIND_EOI;
			res_d.token_begins = 1'b1;
			unique case (phase_q)
				PH_AFTER_LT, PH_AFTER_SLASH: res_d.error_code = ERR_NAME_START;
				PH_NAME, PH_BODY:            res_d.error_code = ERR_ATTR_START;
				PH_KEY, PH_AFTER_KEY:        res_d.error_code = ERR_NO_EQ;
				PH_AFTER_EQ:                 res_d.error_code = ERR_NO_QUOTE;
				PH_VALUE:                    res_d.error_code = ERR_IN_VALUE;
				PH_CONTENT:                  res_d.content_closed = 1'b1;
				default:                     res_d.error_code = ERR_NONE;
			endcase
			phase_d        = PH_BETWEEN;
			quote_single_d = 1'b0;
			tag_end_d      = 1'b0;
		end else begin
			unique case (phase_q)
				PH_CONTENT: begin
					if (c != CH_LT) begin
						res_d.role       = ROLE_CONTENT;
						res_d.token_kind = KIND_CONTENT;
					end else begin
						res_d.content_closed = 1'b1;
						res_d.role           = ROLE_LT;
						res_d.token_kind     = KIND_START;
						res_d.token_begins   = 1'b1;
						tag_end_d            = 1'b0;
						phase_d              = PH_AFTER_LT;
					end
				end
				PH_AFTER_LT, PH_AFTER_SLASH: begin
					if (phase_q == PH_AFTER_LT && c == CH_SLASH) begin
						tag_end_d        = 1'b1;
						res_d.role       = ROLE_SLASH;
						res_d.token_kind = KIND_ENDTAG;
						phase_d          = PH_AFTER_SLASH;
					end else if (is_name_start(c)) begin
						res_d.role       = ROLE_NAME;
						res_d.token_kind = tag_kind;
						phase_d          = PH_NAME;
					end else begin
						res_d.role       = ROLE_IGNORED;
						res_d.error_code = ERR_NAME_START;
						phase_d          = PH_ERROR;
					end
				end
				PH_NAME, PH_BODY: begin
					res_d.token_kind = tag_kind;
					priority if (phase_q == PH_NAME && is_name_char(c)) begin
						res_d.role = ROLE_NAME;
					end else if (is_blank(c)) begin
						res_d.role = ROLE_SPACE;
						phase_d    = PH_BODY;
					end else if (c == CH_GT) begin
						res_d.role       = ROLE_GT;
						res_d.tag_closed = 1'b1;
						phase_d          = PH_BETWEEN;
					end else if (is_name_start(c)) begin
						res_d.role        = ROLE_KEY;
						res_d.attr_begins = 1'b1;
						phase_d           = PH_KEY;
					end else begin
						res_d.role       = ROLE_IGNORED;
						res_d.token_kind = KIND_NONE;
						res_d.error_code = ERR_ATTR_START;
						phase_d          = PH_ERROR;
					end
				end
				PH_KEY, PH_AFTER_KEY: begin
					res_d.token_kind = tag_kind;
					priority if (phase_q == PH_KEY && is_name_char(c)) begin
						res_d.role = ROLE_KEY;
					end else if (is_blank(c)) begin
						res_d.role = ROLE_SPACE;
						phase_d    = PH_AFTER_KEY;
					end else if (c == CH_EQ) begin
						res_d.role = ROLE_EQ;
						phase_d    = PH_AFTER_EQ;
					end else begin
						res_d.role       = ROLE_IGNORED;
						res_d.token_kind = KIND_NONE;
						res_d.error_code = ERR_NO_EQ;
						phase_d          = PH_ERROR;
					end
				end
				PH_AFTER_EQ: begin
					res_d.token_kind = tag_kind;
					priority if (is_blank(c)) begin
						res_d.role = ROLE_SPACE;
					end else if (c == CH_DQ || c == CH_SQ) begin
						res_d.role     = ROLE_OPENQ;
						quote_single_d = c == CH_SQ;
						phase_d        = PH_VALUE;
					end else begin
						res_d.role       = ROLE_IGNORED;
						res_d.token_kind = KIND_NONE;
						res_d.error_code = ERR_NO_QUOTE;
						phase_d          = PH_ERROR;
					end
				end
				PH_VALUE: begin
					res_d.token_kind = tag_kind;
					if (c == close_quote) begin
						res_d.role        = ROLE_CLOSEQ;
						res_d.attr_closed = 1'b1;
						phase_d           = PH_BODY;
					end else begin
						res_d.role = ROLE_VALUE;
					end
				end
				PH_ERROR: begin
					res_d.role = ROLE_IGNORED;
				end
				default: begin
					priority if (is_blank(c)) begin
						res_d.role = ROLE_SPACE;
					end else if (c == CH_LT) begin
						res_d.role         = ROLE_LT;
						res_d.token_kind   = KIND_START;
						res_d.token_begins = 1'b1;
						tag_end_d          = 1'b0;
						phase_d            = PH_AFTER_LT;
					end else begin
						res_d.role         = ROLE_CONTENT;
						res_d.token_kind   = KIND_CONTENT;
						res_d.token_begins = 1'b1;
						phase_d            = PH_CONTENT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			phase_q        <= PH_BETWEEN;
			quote_single_q <= 1'b0;
			tag_end_q      <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
				item_s1  <= item;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (move) begin
				out_q          <= res_d;
				phase_q        <= phase_d;
				quote_single_q <= quote_single_d;
				tag_end_q      <= tag_end_d;
			end
		end
	end

endmodule

FILE: rtl/xmt_checker.sv
// Port-level checks for the markup tokenizer, bound to its top level.
module xmt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input xmt_pkg::xmt_item_t   item,
	input logic                 result_valid,
	input logic                 result_ready,
	input xmt_pkg::xmt_result_t result
);
	import xmt_pkg::*;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("stalled request changed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.role == ROLE_END |->
			result.token_kind == KIND_EOI && result.token_begins)
		else $error("end result lacks end token");

	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error_code != ERR_NONE |->
			result.role == ROLE_IGNORED || result.role == ROLE_END)
		else $error("error on a byte that is not ignored or end");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.tag_closed |->
			result.role == ROLE_GT && result.token_kind != KIND_NONE)
		else $error("tag closed on a byte other than '>'");

endmodule

bind xml_markup_tokenizer_unit xmt_checker u_xmt_checker (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the markup tokenizer: directed table, then random documents.
`timescale 1ns / 100ps

module testbench;
	import xmt_pkg::*;

	localparam int unsigned ItemTarget = 1200;
	localparam int unsigned CycleLimit = 500_000;
	localparam int unsigned LongHold   = 400;
	localparam int unsigned DrainCycles = 8;

	typedef enum logic [3:0] {
		LX_GAP, LX_OPENED, LX_SLASHED, LX_TAG_NAME, LX_TAG_BODY, LX_ATTR_KEY,
		LX_KEY_DONE, LX_EQ_SEEN, LX_IN_VALUE, LX_TEXT, LX_FAULT
	} lex_phase_t;

	typedef struct packed {
		xmt_item_t   stim;
		logic        pinned;
		xmt_result_t want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	xmt_item_t   item;
	logic        result_valid;
	logic        result_ready;
	xmt_result_t result;

	lex_phase_t  lex_phase = LX_GAP;
	logic        single_quoted = 1'b0;
	logic        closing_tag = 1'b0;

	xmt_result_t tokens_due[$];
	xmt_item_t   doc_bytes[$];
	script_row_t script[26];
	int unsigned useful_items = 0;
	int unsigned results_taken = 0;
	int unsigned failures = 0;
	int unsigned cycle_count = 0;
	logic        squeezed = 1'b0;

	xml_markup_tokenizer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	function automatic logic is_blank(logic [CharW-1:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF;
	endfunction

	function automatic logic name_start(logic [CharW-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_USCORE;
	endfunction

	function automatic logic name_char(logic [CharW-1:0] c);
		return name_start(c) || c == CH_DASH || c == CH_DOT || (c >= "0" && c <= "9");
	endfunction

	function automatic xmt_result_t tokenize_byte(xmt_item_t it);
		xmt_result_t r;
		logic [CharW-1:0] c;
		logic [KindW-1:0] tk;
		logic [ErrorW-1:0] err;
		c = it.char_in;
		r = '0;
		r.char_out = c;
		tk = closing_tag ? KIND_ENDTAG : KIND_START;
		err = ERR_NONE;
		if (it.end_of_input || c == CH_NUL) begin
			case (lex_phase)
				LX_OPENED, LX_SLASHED:    r.error_code = ERR_NAME_START;
				LX_TAG_NAME, LX_TAG_BODY: r.error_code = ERR_ATTR_START;
				LX_ATTR_KEY, LX_KEY_DONE: r.error_code = ERR_NO_EQ;
				LX_EQ_SEEN:               r.error_code = ERR_NO_QUOTE;
				LX_IN_VALUE:              r.error_code = ERR_IN_VALUE;
				LX_TEXT:                  r.content_closed = 1'b1;
				default: ;
			endcase
			r.role = ROLE_END;
			r.token_kind = KIND_EOI;
			r.token_begins = 1'b1;
			lex_phase = LX_GAP;
			closing_tag = 1'b0;
			single_quoted = 1'b0;
			return r;
		end
		case (lex_phase)
			LX_GAP, LX_TEXT: begin
				if (c == CH_LT) begin
					r.content_closed = (lex_phase == LX_TEXT);
					r.role = ROLE_LT;
					r.token_kind = KIND_START;
					r.token_begins = 1'b1;
					closing_tag = 1'b0;
					lex_phase = LX_OPENED;
				end else if (lex_phase == LX_GAP && is_blank(c)) begin
					r.role = ROLE_SPACE;
				end else begin
					r.role = ROLE_CONTENT;
					r.token_kind = KIND_CONTENT;
					r.token_begins = (lex_phase == LX_GAP);
					lex_phase = LX_TEXT;
				end
			end
			LX_OPENED, LX_SLASHED: begin
				if (lex_phase == LX_OPENED && c == CH_SLASH) begin
					closing_tag = 1'b1;
					r.role = ROLE_SLASH;
					r.token_kind = KIND_ENDTAG;
					lex_phase = LX_SLASHED;
				end else if (name_start(c)) begin
					r.role = ROLE_NAME;
					r.token_kind = tk;
					lex_phase = LX_TAG_NAME;
				end else begin
					err = ERR_NAME_START;
				end
			end
			LX_TAG_NAME, LX_TAG_BODY: begin
				r.token_kind = tk;
				if (lex_phase == LX_TAG_NAME && name_char(c)) begin
					r.role = ROLE_NAME;
				end else if (is_blank(c)) begin
					r.role = ROLE_SPACE;
					lex_phase = LX_TAG_BODY;
				end else if (c == CH_GT) begin
					r.role = ROLE_GT;
					r.tag_closed = 1'b1;
					lex_phase = LX_GAP;
				end else if (name_start(c)) begin
					r.role = ROLE_KEY;
					r.attr_begins = 1'b1;
					lex_phase = LX_ATTR_KEY;
				end else begin
					err = ERR_ATTR_START;
				end
			end
			LX_ATTR_KEY, LX_KEY_DONE: begin
				r.token_kind = tk;
				if (lex_phase == LX_ATTR_KEY && name_char(c)) begin
					r.role = ROLE_KEY;
				end else if (is_blank(c)) begin
					r.role = ROLE_SPACE;
					lex_phase = LX_KEY_DONE;
				end else if (c == CH_EQ) begin
					r.role = ROLE_EQ;
					lex_phase = LX_EQ_SEEN;
				end else begin
					err = ERR_NO_EQ;
				end
			end
			LX_EQ_SEEN: begin
				r.token_kind = tk;
				if (is_blank(c)) begin
					r.role = ROLE_SPACE;
				end else if (c == CH_DQ || c == CH_SQ) begin
					r.role = ROLE_OPENQ;
					single_quoted = (c == CH_SQ);
					lex_phase = LX_IN_VALUE;
				end else begin
					err = ERR_NO_QUOTE;
				end
			end
			LX_IN_VALUE: begin
				r.token_kind = tk;
				if (c == (single_quoted ? CH_SQ : CH_DQ)) begin
					r.role = ROLE_CLOSEQ;
					r.attr_closed = 1'b1;
					lex_phase = LX_TAG_BODY;
				end else begin
					r.role = ROLE_VALUE;
				end
			end
			default: r.role = ROLE_IGNORED;
		endcase
		if (err != ERR_NONE) begin
			r.role = ROLE_IGNORED;
			r.token_kind = KIND_NONE;
			r.error_code = err;
			lex_phase = LX_FAULT;
		end
		return r;
	endfunction

	function automatic xmt_item_t data_byte(logic [CharW-1:0] c);
		xmt_item_t it;
		it.char_in = c;
		it.end_of_input = 1'b0;
		return it;
	endfunction

	function automatic xmt_item_t doc_end(logic [CharW-1:0] c);
		xmt_item_t it;
		it.char_in = c;
		it.end_of_input = 1'b1;
		return it;
	endfunction

	function automatic script_row_t free_row(xmt_item_t it);
		script_row_t row;
		row = '0;
		row.stim = it;
		return row;
	endfunction

	function automatic script_row_t pin_row(xmt_item_t it, logic [RoleW-1:0] role,
			logic [KindW-1:0] kind, logic begins, logic cut, logic [ErrorW-1:0] err);
		script_row_t row;
		row = '0;
		row.stim = it;
		row.pinned = 1'b1;
		row.want.char_out = it.char_in;
		row.want.role = role;
		row.want.token_kind = kind;
		row.want.token_begins = begins;
		row.want.content_closed = cut;
		row.want.error_code = err;
		return row;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CharW-1:0] any_name_start();
		int unsigned r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'(8'h61 + r);
		if (r < 52)
			return 8'(8'h41 + r - 26);
		return CH_USCORE;
	endfunction

	function automatic logic [CharW-1:0] any_name_char();
		int unsigned r;
		r = $urandom_range(0, 64);
		if (r < 53)
			return any_name_start();
		if (r < 63)
			return 8'(8'h30 + r - 53);
		return (r == 63) ? CH_DASH : CH_DOT;
	endfunction

	function automatic logic [CharW-1:0] any_blank();
		case ($urandom_range(0, 2))
			0: return CH_SP;
			1: return CH_TAB;
			default: return CH_LF;
		endcase
	endfunction

	task automatic add_char(logic [CharW-1:0] c);
		doc_bytes = {doc_bytes, data_byte(c)};
	endtask

	task automatic add_blanks(int unsigned n);
		repeat (n) add_char(any_blank());
	endtask

	task automatic add_name(int unsigned len);
		add_char(any_name_start());
		repeat (len - 1) add_char(any_name_char());
	endtask

	task automatic add_text();
		logic [CharW-1:0] v;
		repeat ($urandom_range(1, 8)) begin
			do
				v = 8'($urandom_range(1, 255));
			while (v == CH_LT);
			add_char(v);
		end
	endtask

	task automatic add_tag(logic closing);
		logic [CharW-1:0] q;
		logic [CharW-1:0] v;
		add_char(CH_LT);
		if (closing)
			add_char(CH_SLASH);
		add_name($urandom_range(1, 6));
		repeat ($urandom_range(0, closing ? 1 : 3)) begin
			add_blanks($urandom_range(1, 2));
			add_name($urandom_range(1, 5));
			add_blanks($urandom_range(0, 1));
			add_char(CH_EQ);
			add_blanks($urandom_range(0, 1));
			q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
			add_char(q);
			repeat ($urandom_range(0, 5)) begin
				do
					v = 8'($urandom_range(1, 255));
				while (v == q);
				add_char(v);
			end
			add_char(q);
		end
		add_blanks($urandom_range(0, 1));
		add_char(CH_GT);
	endtask

	task automatic offer(xmt_item_t it, xmt_result_t want, int unsigned gap);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tokens_due = {tokens_due, want};
		useful_items++;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("xml_markup_tokenizer_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin : check_results
		xmt_result_t due;
		if (arst_n && result_valid && result_ready) begin
			results_taken <= results_taken + 1;
			if (tokens_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result %p", result);
			end else begin
				due = tokens_due.pop_front();
				if (result !== due) begin
					failures++;
					if (failures <= 10)
						$display("wrong result: expected %p, got %p", due, result);
				end
			end
		end
	end

	initial begin : drain_results
		int unsigned stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!squeezed && results_taken >= 300) begin
				squeezed = 1'b1;
				result_ready <= 1'b0;
				repeat (LongHold) @(negedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	initial begin : feed_document
		int unsigned sel;
		int unsigned cut;
		logic calm;
		item_valid = 1'b0;
		item = '0;
		arst_n = 1'b0;
		script = '{
			free_row(data_byte(CH_SP)),
			pin_row(data_byte(8'hFF), ROLE_CONTENT, KIND_CONTENT, 1'b1, 1'b0, ERR_NONE),
			pin_row(data_byte(CH_LT), ROLE_LT, KIND_START, 1'b1, 1'b1, ERR_NONE),
			free_row(data_byte("a")),
			free_row(data_byte(CH_TAB)),
			free_row(data_byte("k")),
			free_row(data_byte(CH_SP)),
			free_row(data_byte(CH_EQ)),
			free_row(data_byte(CH_LF)),
			free_row(data_byte(CH_SQ)),
			free_row(data_byte(CH_DQ)),
			free_row(data_byte(CH_SQ)),
			free_row(data_byte(CH_GT)),
			free_row(data_byte(CH_LT)),
			free_row(data_byte(CH_SLASH)),
			free_row(data_byte("Z")),
			free_row(data_byte(CH_GT)),
			free_row(data_byte("q")),
			pin_row(doc_end(8'hFF), ROLE_END, KIND_EOI, 1'b1, 1'b1, ERR_NONE),
			free_row(data_byte(CH_LT)),
			pin_row(data_byte("9"), ROLE_IGNORED, KIND_NONE, 1'b0, 1'b0, ERR_NAME_START),
			free_row(data_byte(CH_GT)),
			pin_row(data_byte(CH_NUL), ROLE_END, KIND_EOI, 1'b1, 1'b0, ERR_NONE),
			free_row(data_byte(CH_LT)),
			free_row(data_byte(CH_USCORE)),
			pin_row(data_byte(CH_DQ), ROLE_IGNORED, KIND_NONE, 1'b0, 1'b0, ERR_ATTR_START)
		};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[k]) begin
			xmt_result_t predicted;
			predicted = tokenize_byte(script[k].stim);
			offer(script[k].stim, script[k].pinned ? script[k].want : predicted, pick_gap());
		end

		while (useful_items < ItemTarget) begin
			doc_bytes.delete();
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 3))
					0: add_tag(1'b0);
					1: add_tag(1'b1);
					2: add_text();
					default: add_blanks($urandom_range(1, 3));
				endcase
			end
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				doc_bytes.delete();
				repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(0, 255)));
			end else if (sel < 20) begin
				doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] =
					data_byte(8'($urandom_range(0, 255)));
			end else if (sel < 35) begin
				cut = $urandom_range(0, doc_bytes.size() - 1);
				while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
			end
			if ($urandom_range(0, 1))
				doc_bytes = {doc_bytes, doc_end(8'($urandom_range(0, 255)))};
			else
				add_char(CH_NUL);
			calm = ($urandom_range(0, 3) == 0);
			foreach (doc_bytes[k])
				offer(doc_bytes[k], tokenize_byte(doc_bytes[k]), calm ? 0 : pick_gap());
		end
		item_valid <= 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (failures == 0)
			$display("xml_markup_tokenizer_unit: match");
		else
			$display("xml_markup_tokenizer_unit: mismatch");
		$finish;
	end

endmodule
